FILE: rtl/rpp_pkg.sv
// ----------------------------------------------------------------------------
// rpp_pkg
// Shared types, widths and constants of the radar point projector.
// ----------------------------------------------------------------------------
package rpp_pkg;

  // Datapath widths
  localparam int unsigned CoordW = 16;  // world coordinates
  localparam int unsigned DeltaW = 17;  // point - reference
  localparam int unsigned TrigW  = 16;  // signed Q1.15 sine/cosine
  localparam int unsigned RotW   = 34;  // rotated point, signed Q15
  localparam int unsigned MagW   = 33;  // magnitude of a rotated axis
  localparam int unsigned NumW   = 44;  // magnitude * half_size
  localparam int unsigned QuoW   = 11;  // quotient, never above half_size
  localparam int unsigned ScrW   = 14;  // screen coordinates
  localparam int unsigned CfgW   = 15;  // widest register
  localparam int unsigned CfgIdxW = 2;

  // Register widths
  localparam int unsigned CenterW = 12;
  localparam int unsigned HalfW   = 11;
  localparam int unsigned RangeW  = 15;

  typedef enum logic [CfgIdxW-1:0] {
    CfgCenterX   = 2'd0,
    CfgCenterY   = 2'd1,
    CfgHalfSize  = 2'd2,
    CfgViewRange = 2'd3
  } cfg_idx_e;

  // Sine table generation, Q2.30 Taylor series
  localparam longint Q30One   = 64'sd1073741824;
  localparam longint HalfPiQ30 = 64'sd1686629713;
  localparam longint TaylorDiv [6] = '{64'sd6, 64'sd20, 64'sd42, 64'sd72, 64'sd110, 64'sd156};

  function automatic longint sine_q15(longint a);
    longint term;
    longint sum;
    longint r;
    term = a;
    sum  = a;
    for (int n = 0; n < 6; n++) begin
      term = (term * a) / Q30One;
      term = (term * a) / Q30One;
      term = term / TaylorDiv[n];
      term = -term;
      sum  = sum + term;
    end
    r = (sum + 64'sd16384) / 64'sd32768;
    if (r > 64'sd32767) r = 64'sd32767;
    if (r < 64'sd0) r = 64'sd0;
    return r;
  endfunction

  // Sideband that rides along the divider
  typedef struct packed {
    logic clip;
    logic neg_x;
    logic neg_y;
  } side_t;

endpackage

FILE: rtl/rpp_in_if.sv
// ----------------------------------------------------------------------------
// rpp_in_if
// Input channel: target and viewer positions plus view yaw.
// ----------------------------------------------------------------------------
interface rpp_in_if;
  import rpp_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [CoordW-1:0] point_x;
  logic signed [CoordW-1:0] point_y;
  logic signed [CoordW-1:0] ref_x;
  logic signed [CoordW-1:0] ref_y;
  logic        [15:0]       yaw;

  modport source (output valid, point_x, point_y, ref_x, ref_y, yaw, input ready);
  modport sink   (input valid, point_x, point_y, ref_x, ref_y, yaw, output ready);
endinterface

FILE: rtl/rpp_out_if.sv
// ----------------------------------------------------------------------------
// rpp_out_if
// Output channel: radar marker position and clip flag.
// ----------------------------------------------------------------------------
interface rpp_out_if;
  import rpp_pkg::*;

  logic                   valid;
  logic                   ready;
  logic signed [ScrW-1:0] screen_x;
  logic signed [ScrW-1:0] screen_y;
  logic                   clipped;

  modport source (output valid, screen_x, screen_y, clipped, input ready);
  modport sink   (input valid, screen_x, screen_y, clipped, output ready);
endinterface

FILE: rtl/radar_point_project.sv
// ----------------------------------------------------------------------------
// radar_point_project
// Rotates a world point into view space and projects it onto a square radar.
// ----------------------------------------------------------------------------
//  channel  | dir | beat contents
//  ---------+-----+------------------------------------------------
//  in_if    | in  | point_x, point_y, ref_x, ref_y, yaw
//  out_if   | out | screen_x, screen_y, clipped
//  cfg_*    | in  | write enable, register index, data (no read)
//
//  One beat in per cycle while the output is not stalled (6 datapath stages, 11
//  divider stages, 1 output stage). The divider stages set the depth.
//  Reset clears the valid bits and loads the register defaults.
//  A stalled output freezes the whole pipeline; in_if.ready falls with it.
// ----------------------------------------------------------------------------
module radar_point_project #(
  parameter int unsigned SINE_TABLE_DEPTH = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rpp_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [rpp_pkg::CfgW-1:0]      cfg_data_i,
  rpp_in_if.sink                        in_if,
  rpp_out_if.source                     out_if
);
  import rpp_pkg::*;

  localparam int unsigned IdxW  = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int unsigned ProdW = 14 + IdxW;
  localparam int unsigned Depth = 6 + QuoW;  // stages before the output

  // ---------------- configuration registers ----------------
  logic [CenterW-1:0] center_x_q, center_y_q;
  logic [HalfW-1:0]   half_q;
  logic [RangeW-1:0]  range_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= CenterW'(200);
      center_y_q <= CenterW'(200);
      half_q     <= HalfW'(100);
      range_q    <= RangeW'(2000);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgCenterX:   center_x_q <= cfg_data_i[CenterW-1:0];
        CfgCenterY:   center_y_q <= cfg_data_i[CenterW-1:0];
        CfgHalfSize:  half_q     <= cfg_data_i[HalfW-1:0];
        CfgViewRange: range_q    <= cfg_data_i[RangeW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- sine quarter-wave table ----------------
  logic [14:0] sine_rom [SINE_TABLE_DEPTH+1];
  for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_rom
    localparam longint A = (longint'(k) * HalfPiQ30) / SINE_TABLE_DEPTH;
    assign sine_rom[k] = 15'(sine_q15(A));
  end

  // ---------------- flow control ----------------
  // every stage moves together; valid bits mark live beats
  logic adv;
  logic out_valid_q;
  assign adv         = !out_valid_q || out_if.ready;
  assign in_if.ready = adv;

  logic [Depth-1:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      vld_q       <= {vld_q[Depth-2:0], in_if.valid};
      out_valid_q <= vld_q[Depth-1];
    end
  end

  // ---------------- stage 1: deltas, table index ----------------
  logic signed [DeltaW-1:0] dx1_q, dy1_q;
  logic        [IdxW-1:0]   idx1_q;
  logic        [1:0]        quad1_q;
  logic        [ProdW-1:0]  idx_prod;

  assign idx_prod = ProdW'(in_if.yaw[13:0]) * ProdW'(SINE_TABLE_DEPTH);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dx1_q   <= DeltaW'(in_if.point_x) - DeltaW'(in_if.ref_x);
      dy1_q   <= DeltaW'(in_if.point_y) - DeltaW'(in_if.ref_y);
      idx1_q  <= idx_prod[ProdW-1:14];
      quad1_q <= in_if.yaw[15:14];
    end
  end

  // ---------------- stage 2: sine / cosine ----------------
  logic signed [TrigW-1:0]  sin2_q, cos2_q;
  logic signed [DeltaW-1:0] dx2_q, dy2_q;
  logic signed [TrigW-1:0]  t_i, t_di;
  logic signed [TrigW-1:0]  sin_d, cos_d;

  assign t_i  = $signed({1'b0, sine_rom[idx1_q]});
  assign t_di = $signed({1'b0, sine_rom[IdxW'(SINE_TABLE_DEPTH) - idx1_q]});

  always_comb begin
    case (quad1_q)
      2'd0:    begin sin_d = t_i;   cos_d = t_di;  end
      2'd1:    begin sin_d = t_di;  cos_d = -t_i;  end
      2'd2:    begin sin_d = -t_i;  cos_d = -t_di; end
      default: begin sin_d = -t_di; cos_d = t_i;   end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sin2_q <= sin_d;
      cos2_q <= cos_d;
      dx2_q  <= dx1_q;
      dy2_q  <= dy1_q;
    end
  end

  // ---------------- stage 3: products ----------------
  logic signed [RotW-1:0] p_xs_q, p_yc_q, p_xc_q, p_ys_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_xs_q <= RotW'(dx2_q) * RotW'(sin2_q);
      p_yc_q <= RotW'(dy2_q) * RotW'(cos2_q);
      p_xc_q <= RotW'(dx2_q) * RotW'(cos2_q);
      p_ys_q <= RotW'(dy2_q) * RotW'(sin2_q);
    end
  end

  // ---------------- stage 4: rotation sums ----------------
  logic signed [RotW-1:0] rx4_q, ry4_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      rx4_q <= p_xs_q - p_yc_q;
      ry4_q <= -(p_xc_q + p_ys_q);
    end
  end

  // ---------------- stage 5: magnitudes ----------------
  logic [MagW-1:0] ax5_q, ay5_q;
  logic            nx5_q, ny5_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      ax5_q <= rx4_q[RotW-1] ? MagW'(-rx4_q) : MagW'(rx4_q);
      ay5_q <= ry4_q[RotW-1] ? MagW'(-ry4_q) : MagW'(ry4_q);
      nx5_q <= rx4_q[RotW-1];
      ny5_q <= ry4_q[RotW-1];
    end
  end

  // ---------------- stage 6: clip test, divisor, numerators ----------------
  // clipped: dividing by the dominant magnitude puts that axis at +-half_size
  logic [RangeW-1:0] range_eff;
  logic [MagW-1:0]   lim;
  logic              clip_d;
  logic [MagW-1:0]   den_d;
  logic [NumW-1:0]   numx6_q, numy6_q;
  logic [MagW-1:0]   den6_q;
  side_t             side6_q;

  assign range_eff = (range_q == '0) ? RangeW'(1) : range_q;
  assign lim       = MagW'(range_eff) << 15;
  assign clip_d    = (ax5_q > lim) || (ay5_q > lim);
  assign den_d     = clip_d ? ((ax5_q > ay5_q) ? ax5_q : ay5_q) : lim;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      numx6_q <= NumW'(ax5_q) * NumW'(half_q);
      numy6_q <= NumW'(ay5_q) * NumW'(half_q);
      den6_q  <= den_d;
      side6_q <= '{clip: clip_d, neg_x: nx5_q, neg_y: ny5_q};
    end
  end

  // ---------------- divider stages ----------------
  logic [QuoW-1:0] qx, qy;

  rpp_div u_div_x (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (numx6_q),
    .den_i (den6_q),
    .quo_o (qx)
  );

  rpp_div u_div_y (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (numy6_q),
    .den_i (den6_q),
    .quo_o (qy)
  );

  side_t side_q [QuoW];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0] <= side6_q;
      for (int j = 1; j < QuoW; j++) side_q[j] <= side_q[j-1];
    end
  end

  // ---------------- output stage: sign and centre offset ----------------
  logic signed [ScrW-1:0] ox, oy;
  logic signed [ScrW-1:0] sx_q, sy_q;
  logic                   clip_q;

  assign ox = side_q[QuoW-1].neg_x ? -$signed(ScrW'(qx)) : $signed(ScrW'(qx));
  assign oy = side_q[QuoW-1].neg_y ? -$signed(ScrW'(qy)) : $signed(ScrW'(qy));

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sx_q   <= $signed(ScrW'(center_x_q)) + ox;
      sy_q   <= $signed(ScrW'(center_y_q)) + oy;
      clip_q <= side_q[QuoW-1].clip;
    end
  end

  assign out_if.valid    = out_valid_q;
  assign out_if.screen_x = sx_q;
  assign out_if.screen_y = sy_q;
  assign out_if.clipped  = clip_q;
endmodule

FILE: rtl/rpp_div.sv
// ----------------------------------------------------------------------------
// rpp_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module rpp_div (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [rpp_pkg::NumW-1:0]    num_i,
  input  logic [rpp_pkg::MagW-1:0]    den_i,
  output logic [rpp_pkg::QuoW-1:0]    quo_o
);
  import rpp_pkg::*;

  // caller guarantees num < den * 2^QuoW
  logic [NumW-1:0] rem_q [QuoW];
  logic [MagW-1:0] den_q [QuoW];
  logic [QuoW-1:0] quo_q [QuoW];

  for (genvar j = 0; j < QuoW; j++) begin : g_stage
    localparam int unsigned Bit = QuoW - 1 - j;
    logic [NumW-1:0] rem_in;
    logic [MagW-1:0] den_in;
    logic [QuoW-1:0] quo_in;
    logic [NumW-1:0] trial;
    logic            take;

    if (j == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign den_in = den_q[j-1];
      assign quo_in = quo_q[j-1];
    end

    assign trial = NumW'(den_in) << Bit;
    assign take  = rem_in >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j] <= take ? rem_in - trial : rem_in;
        den_q[j] <= den_in;
        quo_q[j] <= quo_in | (QuoW'(take) << Bit);
      end
    end
  end

  assign quo_o = quo_q[QuoW-1];
endmodule

FILE: rtl/rpp_checker.sv
// ----------------------------------------------------------------------------
// rpp_checker
// Port-level assertions on the radar point projector, bound to the top.
// ----------------------------------------------------------------------------
module rpp_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [rpp_pkg::ScrW-1:0]     screen_x_i,
  input logic [rpp_pkg::ScrW-1:0]     screen_y_i,
  input logic                         clipped_i
);
  import rpp_pkg::*;

  // stalled beat holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(screen_x_i)
      && $stable(screen_y_i) && $stable(clipped_i))
    else $error("output beat changed while stalled");

  // empty output register never blocks the input
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input blocked with output empty");

  // a stalled output freezes the pipe
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("input taken while output stalled");

  // with the output empty and no input offered, the output turns valid only if the pipe could advance
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i && !in_valid_i |=> !out_valid_i || $past(in_ready_i))
    else $error("output appeared without pipeline advance");
endmodule

bind radar_point_project rpp_checker u_rpp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_if.valid),
  .in_ready_i  (in_if.ready),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .screen_x_i  (out_if.screen_x),
  .screen_y_i  (out_if.screen_y),
  .clipped_i   (out_if.clipped)
);
